// ===== rtl/core/clr_pkg.sv =====
// Shared types and constants of the clipped line rasterizer.
package clr_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int MAX_CUTS      = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int LEFT_W        = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT   = 3'd0,
        CFG_CLIP_TOP    = 3'd1,
        CFG_CLIP_RIGHT  = 3'd2,
        CFG_CLIP_BOTTOM = 3'd3,
        CFG_OFFSET_X    = 3'd4,
        CFG_OFFSET_Y    = 3'd5,
        CFG_BRUSH       = 3'd6
    } t_cfg_idx;

    localparam logic signed [15:0] RST_CLIP_LEFT   = 16'sd0;
    localparam logic signed [15:0] RST_CLIP_TOP    = 16'sd0;
    localparam logic signed [15:0] RST_CLIP_RIGHT  = 16'sd127;
    localparam logic signed [15:0] RST_CLIP_BOTTOM = 16'sd63;
    localparam logic               RST_BRUSH       = 1'b1;

    // outcode bits
    localparam logic [3:0] OC_TOP    = 4'd1;
    localparam logic [3:0] OC_BOTTOM = 4'd2;
    localparam logic [3:0] OC_LEFT   = 4'd4;
    localparam logic [3:0] OC_RIGHT  = 4'd8;

    typedef struct packed {
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic               brush;
    } t_cfg;

    // queued command, endpoints already offset
    typedef struct packed {
        logic               is_tick;
        logic signed [16:0] x1;
        logic signed [16:0] y1;
        logic signed [16:0] x2;
        logic signed [16:0] y2;
    } t_cmd;

endpackage

// ===== rtl/core/clr_in_if.sv =====
// Input channel: line commands and step ticks.
interface clr_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;

    modport source (output valid, req_type, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, req_type, x_start, y_start, x_end, y_end, output ready);
endinterface

// ===== rtl/core/clr_out_if.sv =====
// Output channel: plotted pixels.
interface clr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               color;
    logic               last_pixel;

    modport source (output valid, pixel_x, pixel_y, color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, color, last_pixel, output ready);
endinterface

// ===== rtl/core/clr_front.sv =====
// Front end: accepts items, applies the offset, queues commands.
module clr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    clr_in_if.sink             i_line,
    input  clr_pkg::t_cfg      i_cfg,
    output logic               o_cmd_valid,
    output clr_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_pop
);
    import clr_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_cnt;
    logic           push;
    logic           pop;
    t_cmd           cmd_in;

    assign i_line.ready = (r_cnt != QCW'(QUEUE_DEPTH));
    assign push         = i_line.valid && i_line.ready;
    assign pop          = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid  = (r_cnt != '0);
    assign o_cmd        = r_mem[r_rptr];

    always_comb begin
        cmd_in.is_tick = i_line.req_type;
        cmd_in.x1      = 17'(i_line.x_start) + 17'(i_cfg.offset_x);
        cmd_in.y1      = 17'(i_line.y_start) + 17'(i_cfg.offset_y);
        cmd_in.x2      = 17'(i_line.x_end) + 17'(i_cfg.offset_x);
        cmd_in.y2      = 17'(i_line.y_end) + 17'(i_cfg.offset_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_mem[r_wptr] <= cmd_in;
                r_wptr <= (r_wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== rtl/core/clr_div.sv =====
// Signed radix-2 restoring divider, quotient truncated toward zero.
module clr_div #(
    parameter int NW = 54,
    parameter int DW = 27
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quot
);
    localparam int CNTW = $clog2(NW + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNTW-1:0]      r_cnt;
    logic [NW-1:0]        r_q;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_dmag;
    logic                 r_neg;
    logic                 r_dz;
    logic signed [NW-1:0] r_quot;
    logic [DW:0]          rem_sh;
    logic [DW:0]          diff;
    logic                 ge;
    logic [NW-1:0]        nmag;
    logic [DW-1:0]        dmag;

    assign nmag   = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign dmag   = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign rem_sh = {r_rem, r_q[NW-1]};
    assign ge     = (rem_sh >= {1'b0, r_dmag});
    assign diff   = rem_sh - {1'b0, r_dmag};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
                r_q    <= nmag;
                r_rem  <= '0;
                r_dmag <= dmag;
                r_neg  <= i_num[NW-1] ^ i_den[DW-1];
                r_dz   <= (i_den == '0);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_q   <= {r_q[NW-2:0], ge};
                    r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= r_dz ? '0 : (r_neg ? -signed'(r_q) : signed'(r_q));
                end
            end
        end
    end
endmodule

// ===== rtl/core/clr_back.sv =====
// Back end: clipping sequencer, DDA setup and pixel stepping.
module clr_back #(
    parameter int FRAC_BITS = clr_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  clr_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  clr_pkg::t_cfg      i_cfg,
    clr_out_if.source          o_pix
);
    import clr_pkg::*;

    localparam int CW = 19 + FRAC_BITS;   // scaled coordinates and differences
    localparam int NW = 2 * CW;           // product / dividend
    localparam int AW = CW + 1;           // accumulators
    localparam int NCW = $clog2(MAX_CUTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_MUL, S_DIVS, S_DIVW, S_UPD,
        S_STEP, S_DXS, S_DXW, S_DYS, S_DYW
    } t_state;

    t_state               r_state;
    logic signed [CW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [NCW-1:0]       r_n;
    logic                 r_sel1;
    logic                 r_horiz;
    logic signed [CW-1:0] r_ma, r_mb, r_den, r_base, r_fix;
    logic signed [NW-1:0] r_prod;
    logic signed [CW-1:0] r_steps;
    logic signed [CW-1:0] r_xstep, r_ystep;
    logic signed [AW-1:0] r_xacc, r_yacc;
    logic [LEFT_W-1:0]    r_left;
    logic                 r_ov;
    logic signed [15:0]   r_px, r_py;
    logic                 r_col, r_last;

    logic signed [CW-1:0] wl, wt, wr, wb;
    logic [3:0]           c1, c2, oc;
    logic signed [CW-1:0] dx, dy, adx, ady, cutv, qcw, steps_sh;
    logic signed [AW-1:0] half, xfl, yfl;
    logic                 out_free;
    logic                 pix_load;
    logic                 div_start, div_done;
    logic signed [NW-1:0] div_num, div_quot;
    logic signed [CW-1:0] div_den;

    function automatic logic [3:0] f_outcode(
        input logic signed [CW-1:0] x, y, l, t, r, b
    );
        logic [3:0] c;
        c = '0;
        if (y < t) c |= OC_TOP;
        else if (y > b) c |= OC_BOTTOM;
        if (x < l) c |= OC_LEFT;
        else if (x > r) c |= OC_RIGHT;
        return c;
    endfunction

    assign wl = CW'(i_cfg.clip_left) <<< FRAC_BITS;
    assign wt = CW'(i_cfg.clip_top) <<< FRAC_BITS;
    assign wr = CW'(i_cfg.clip_right) <<< FRAC_BITS;
    assign wb = CW'(i_cfg.clip_bottom) <<< FRAC_BITS;

    assign c1 = f_outcode(r_x1, r_y1, wl, wt, wr, wb);
    assign c2 = f_outcode(r_x2, r_y2, wl, wt, wr, wb);
    assign oc = (c1 != '0) ? c1 : c2;

    assign dx       = r_x2 - r_x1;
    assign dy       = r_y2 - r_y1;
    assign adx      = dx[CW-1] ? -dx : dx;
    assign ady      = dy[CW-1] ? -dy : dy;
    assign qcw      = div_quot[CW-1:0];
    assign cutv     = qcw + r_base;
    assign steps_sh = r_steps >>> FRAC_BITS;
    assign half     = AW'(1) <<< (FRAC_BITS - 1);
    assign xfl      = r_xacc >>> FRAC_BITS;
    assign yfl      = r_yacc >>> FRAC_BITS;
    assign out_free = !r_ov || o_pix.ready;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid &&
                       (!i_cmd.is_tick || r_left == '0 || out_free);

    // tick on an active line loads the output register
    assign pix_load = o_cmd_pop && i_cmd.is_tick && (r_left != '0);

    // divider operands: cut product, or scaled deltas over steps
    assign div_start = (r_state == S_DIVS) || (r_state == S_DXS) || (r_state == S_DYS);
    always_comb begin
        case (r_state)
            S_DIVS:  div_num = r_prod;
            S_DXS:   div_num = NW'(r_ma) <<< FRAC_BITS;
            default: div_num = NW'(r_mb) <<< FRAC_BITS;
        endcase
        div_den = (r_state == S_DIVS) ? r_den : r_steps;
    end

    clr_div #(.NW(NW), .DW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_pix.valid      = r_ov;
    assign o_pix.pixel_x    = r_px;
    assign o_pix.pixel_y    = r_py;
    assign o_pix.color      = r_col;
    assign o_pix.last_pixel = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_left  <= '0;
            r_xacc  <= '0;
            r_yacc  <= '0;
            r_xstep <= '0;
            r_ystep <= '0;
        end else begin
            if (pix_load) r_ov <= 1'b1;
            else if (r_ov && o_pix.ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && i_cmd.is_tick) begin
                        if (r_left != '0) begin
                            r_px   <= xfl[15:0];
                            r_py   <= yfl[15:0];
                            r_col  <= i_cfg.brush;
                            r_last <= (r_left == LEFT_W'(1));
                            r_left <= r_left - 1'b1;
                            r_xacc <= r_xacc + AW'(r_xstep);
                            r_yacc <= r_yacc + AW'(r_ystep);
                        end
                    end else if (o_cmd_pop) begin
                        r_left <= '0;
                        r_n    <= '0;
                        r_x1   <= CW'(i_cmd.x1) <<< FRAC_BITS;
                        r_y1   <= CW'(i_cmd.y1) <<< FRAC_BITS;
                        r_x2   <= CW'(i_cmd.x2) <<< FRAC_BITS;
                        r_y2   <= CW'(i_cmd.y2) <<< FRAC_BITS;
                        // empty window rejects everything
                        if (i_cfg.clip_left <= i_cfg.clip_right &&
                            i_cfg.clip_top <= i_cfg.clip_bottom) begin
                            r_state <= S_LOOP;
                        end
                    end
                end
                S_LOOP: begin
                    if ((c1 | c2) == '0) begin
                        r_state <= S_STEP;
                    end else if ((c1 & c2) != '0 || r_n == NCW'(MAX_CUTS)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_sel1  <= (c1 != '0);
                        r_state <= S_MUL;
                        if ((oc & (OC_TOP | OC_BOTTOM)) != '0) begin
                            r_horiz <= 1'b1;
                            r_fix   <= ((oc & OC_TOP) != '0) ? wt : wb;
                            r_ma    <= dx;
                            r_mb    <= (((oc & OC_TOP) != '0) ? wt : wb) - r_y1;
                            r_den   <= dy;
                            r_base  <= r_x1;
                        end else begin
                            r_horiz <= 1'b0;
                            r_fix   <= ((oc & OC_LEFT) != '0) ? wl : wr;
                            r_ma    <= dy;
                            r_mb    <= (((oc & OC_LEFT) != '0) ? wl : wr) - r_x1;
                            r_den   <= dx;
                            r_base  <= r_y1;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= NW'(r_ma) * NW'(r_mb);
                    r_state <= S_DIVS;
                end
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: if (div_done) r_state <= S_UPD;
                S_UPD: begin
                    if (r_sel1) begin
                        r_x1 <= r_horiz ? cutv : r_fix;
                        r_y1 <= r_horiz ? r_fix : cutv;
                    end else begin
                        r_x2 <= r_horiz ? cutv : r_fix;
                        r_y2 <= r_horiz ? r_fix : cutv;
                    end
                    r_n     <= r_n + 1'b1;
                    r_state <= S_LOOP;
                end
                S_STEP: begin
                    r_ma    <= dx;
                    r_mb    <= dy;
                    r_steps <= (adx > ady) ? adx : ady;
                    r_state <= S_DXS;
                end
                S_DXS: r_state <= S_DXW;
                S_DXW: begin
                    if (div_done) begin
                        r_xstep <= qcw;
                        r_state <= S_DYS;
                    end
                end
                S_DYS: r_state <= S_DYW;
                S_DYW: begin
                    if (div_done) begin
                        r_ystep <= qcw;
                        r_xacc  <= AW'(r_x1) + half;
                        r_yacc  <= AW'(r_y1) + half;
                        r_left  <= steps_sh[LEFT_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/clipped_line_rasterizer.sv =====
// Top level of the clipped line rasterizer: config registers, front and back.
//
// i_line takes items: req_type 0 is a line command (two endpoints), 1 a step
// tick. o_pix gives one pixel per tick while a line is active; last_pixel
// marks the final one. Ticks with no active line and line commands give
// nothing. i_cfg_we/i_cfg_idx/i_cfg_data write the clip window, offset and
// brush; write only while the block is idle.
//
// A two-entry queue sits between the front (accept, offset) and the back
// (clip, DDA). Ticks flow at one per cycle unless o_pix stalls or a line
// setup runs; a tick's pixel passes the queue and the output register.
// A line command's setup makes up to 16 clipping cuts; each cut and each
// DDA increment goes through one shared bit-serial divider with a divisor
// of CW = 19 + FRAC_BITS bits, one quotient bit a cycle.
// Items behind a line command wait in the queue during setup.
//
// Reset (synchronous, active low) empties the queue, drops any line and the
// pending pixel, and restores the config defaults. A stalled o_pix holds its
// pixel; the queue keeps accepting until it is full.
module clipped_line_rasterizer #(
    parameter int FRAC_BITS = clr_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    clr_in_if.sink                         i_line,
    clr_out_if.source                      o_pix,
    input  logic                           i_cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [clr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clr_pkg::*;

    t_cfg r_cfg;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // config register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left   <= RST_CLIP_LEFT;
            r_cfg.clip_top    <= RST_CLIP_TOP;
            r_cfg.clip_right  <= RST_CLIP_RIGHT;
            r_cfg.clip_bottom <= RST_CLIP_BOTTOM;
            r_cfg.offset_x    <= '0;
            r_cfg.offset_y    <= '0;
            r_cfg.brush       <= RST_BRUSH;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CLIP_LEFT:   r_cfg.clip_left   <= signed'(i_cfg_data);
                CFG_CLIP_TOP:    r_cfg.clip_top    <= signed'(i_cfg_data);
                CFG_CLIP_RIGHT:  r_cfg.clip_right  <= signed'(i_cfg_data);
                CFG_CLIP_BOTTOM: r_cfg.clip_bottom <= signed'(i_cfg_data);
                CFG_OFFSET_X:    r_cfg.offset_x    <= signed'(i_cfg_data);
                CFG_OFFSET_Y:    r_cfg.offset_y    <= signed'(i_cfg_data);
                CFG_BRUSH:       r_cfg.brush       <= i_cfg_data[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    clr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_line      (i_line),
        .i_cfg       (r_cfg),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    clr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (r_cfg),
        .o_pix       (o_pix)
    );
endmodule

// ===== rtl/core/clr_chk.sv =====
// Port-level assertions for the rasterizer, bound to the top level.
module clr_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_px,
    input logic signed [15:0] i_py,
    input logic               i_col,
    input logic               i_last
);
    // reset drops the pending pixel
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("pixel valid after reset");

    // reset empties the queue
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled pixel dropped");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_px) && $stable(i_py) && $stable(i_col) && $stable(i_last))
        else $error("stalled pixel changed");
endmodule

bind clipped_line_rasterizer clr_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_line.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_px        (o_pix.pixel_x),
    .i_py        (o_pix.pixel_y),
    .i_col       (o_pix.color),
    .i_last      (o_pix.last_pixel)
);

// ===== tb/clipped_line_rasterizer_tb.sv =====
// Self-checking testbench for the clipped line rasterizer.
module clipped_line_rasterizer_tb;
    import clr_pkg::*;

    // one input item as driven on the line channel
    typedef struct {
        logic               req_type;
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [15:0] xe;
        logic signed [15:0] ye;
    } line_req_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               color;
        logic               last;
    } pixel_t;

    // directed row; typed rows carry a hand-written expectation
    typedef struct {
        line_req_t req;
        bit        typed;
        bit        has_pix;
        pixel_t    pix;
    } dir_row_t;

    localparam logic REQ_LINE = 1'b0;
    localparam logic REQ_TICK = 1'b1;
    localparam int   IDLE_PCT = 23;
    // worst line setup: 16 cuts plus two DDA divisions, rounded up
    localparam int   SETUP_CYCLES = 1200;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    clr_in_if  line_ch();
    clr_out_if pix_ch();

    clipped_line_rasterizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_line     (line_ch.sink),
        .o_pix      (pix_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor state: configuration shadow and DDA
    // ---------------------------------------------------------------
    logic signed [15:0] win_l, win_t, win_r, win_b, off_x, off_y;
    logic               brush_col;
    longint             acc_x, acc_y, inc_x, inc_y;
    int unsigned        pix_remaining;

    pixel_t    pixels_due[$];   // expected pixels, oldest first
    dir_row_t  typed_pend[$];   // per sent item, popped on acceptance
    int        errors;
    int        n_lines, n_ticks, n_pixels, n_accepted_lines;
    bit        steady;          // no idling on either side
    int        hold_cycles;     // receiver hold-off request

    function automatic logic [3:0] region_code(longint x, longint y,
                                               longint l, longint t,
                                               longint r, longint b);
        logic [3:0] c;
        c = '0;
        if (y < t) c |= OC_TOP;
        else if (y > b) c |= OC_BOTTOM;
        if (x < l) c |= OC_LEFT;
        else if (x > r) c |= OC_RIGHT;
        return c;
    endfunction

    function automatic longint edge_cut(longint d, longint e, longint den);
        if (den == 0) return 0;
        return (d * e) / den;   // truncates toward zero
    endfunction

    // clip the segment and load the DDA; rejected or short lines leave none active
    function automatic void load_segment(line_req_t rq);
        longint l, t, r, b, x1, y1, x2, y2, nx, ny, dx, dy, adx, ady, span;
        logic [3:0] c1, c2, oc;
        bit ok;
        l  = longint'(win_l) <<< FRAC_BITS_DEF;
        t  = longint'(win_t) <<< FRAC_BITS_DEF;
        r  = longint'(win_r) <<< FRAC_BITS_DEF;
        b  = longint'(win_b) <<< FRAC_BITS_DEF;
        x1 = (longint'(rq.xs) + longint'(off_x)) <<< FRAC_BITS_DEF;
        y1 = (longint'(rq.ys) + longint'(off_y)) <<< FRAC_BITS_DEF;
        x2 = (longint'(rq.xe) + longint'(off_x)) <<< FRAC_BITS_DEF;
        y2 = (longint'(rq.ye) + longint'(off_y)) <<< FRAC_BITS_DEF;
        ok = 0;
        pix_remaining = 0;
        if (l > r || t > b) return;
        c1 = region_code(x1, y1, l, t, r, b);
        c2 = region_code(x2, y2, l, t, r, b);
        for (int n = 0; n <= MAX_CUTS; n++) begin
            if ((c1 | c2) == 0) begin
                ok = 1;
                break;
            end
            if ((c1 & c2) != 0 || n == MAX_CUTS) break;
            oc = (c1 != 0) ? c1 : c2;
            if (oc & OC_TOP) begin
                ny = t; nx = edge_cut(x2 - x1, t - y1, y2 - y1) + x1;
            end else if (oc & OC_BOTTOM) begin
                ny = b; nx = edge_cut(x2 - x1, b - y1, y2 - y1) + x1;
            end else if (oc & OC_LEFT) begin
                nx = l; ny = edge_cut(y2 - y1, l - x1, x2 - x1) + y1;
            end else begin
                nx = r; ny = edge_cut(y2 - y1, r - x1, x2 - x1) + y1;
            end
            if (oc == c1) begin
                x1 = nx; y1 = ny; c1 = region_code(x1, y1, l, t, r, b);
            end else begin
                x2 = nx; y2 = ny; c2 = region_code(x2, y2, l, t, r, b);
            end
        end
        if (!ok) return;
        dx   = x2 - x1;
        dy   = y2 - y1;
        adx  = dx < 0 ? -dx : dx;
        ady  = dy < 0 ? -dy : dy;
        span = adx > ady ? adx : ady;
        acc_x = x1 + (64'sd1 <<< (FRAC_BITS_DEF - 1));
        acc_y = y1 + (64'sd1 <<< (FRAC_BITS_DEF - 1));
        inc_x = span != 0 ? (dx <<< FRAC_BITS_DEF) / span : 0;
        inc_y = span != 0 ? (dy <<< FRAC_BITS_DEF) / span : 0;
        pix_remaining = int'(span >>> FRAC_BITS_DEF) & 32'h3FFFF;
        if (pix_remaining != 0) n_accepted_lines++;
    endfunction

    function automatic bit next_pixel(output pixel_t p);
        longint fxp, fyp;
        if (pix_remaining == 0) return 0;
        fxp = acc_x >>> FRAC_BITS_DEF;   // arithmetic shift = floor
        fyp = acc_y >>> FRAC_BITS_DEF;
        p.x = fxp[15:0];
        p.y = fyp[15:0];
        p.color = brush_col;
        pix_remaining--;
        p.last = (pix_remaining == 0);
        acc_x += inc_x;
        acc_y += inc_y;
        return 1;
    endfunction

    // ---------------------------------------------------------------
    // Clock, limit
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("timeout at %0t", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // Acceptance monitor: run the predictor on every accepted item
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && line_ch.valid && line_ch.ready) begin
            dir_row_t  row;
            line_req_t rq;
            pixel_t    p;
            bit        got;
            row = typed_pend.pop_front();
            rq.req_type = line_ch.req_type;
            rq.xs = line_ch.x_start;
            rq.ys = line_ch.y_start;
            rq.xe = line_ch.x_end;
            rq.ye = line_ch.y_end;
            if (rq.req_type == REQ_LINE) begin
                n_lines++;
                load_segment(rq);
                got = 0;
            end else begin
                n_ticks++;
                got = next_pixel(p);
            end
            // hand-typed rows override the predictor's answer
            if (row.typed) begin
                got = row.has_pix;
                p   = row.pix;
            end
            if (got) pixels_due.push_back(p);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            pixel_t want;
            n_pixels++;
            if (pixels_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel (%0d,%0d) color %0b last %0b", $time,
                         pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.color, pix_ch.last_pixel);
            end else begin
                want = pixels_due.pop_front();
                if (pix_ch.pixel_x !== want.x) begin
                    errors++;
                    $display("%0t: pixel_x expected %0d got %0d", $time, want.x,
                             pix_ch.pixel_x);
                end
                if (pix_ch.pixel_y !== want.y) begin
                    errors++;
                    $display("%0t: pixel_y expected %0d got %0d", $time, want.y,
                             pix_ch.pixel_y);
                end
                if (pix_ch.color !== want.color) begin
                    errors++;
                    $display("%0t: color expected %0b got %0b", $time, want.color,
                             pix_ch.color);
                end
                if (pix_ch.last_pixel !== want.last) begin
                    errors++;
                    $display("%0t: last_pixel expected %0b got %0b", $time, want.last,
                             pix_ch.last_pixel);
                end
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    initial begin
        pix_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                pix_ch.ready <= 1'b0;
                hold_cycles--;
            end else begin
                pix_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    task automatic send_req(line_req_t rq, dir_row_t row);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            line_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_pend.push_back(row);
        line_ch.valid    <= 1'b1;
        line_ch.req_type <= rq.req_type;
        line_ch.x_start  <= rq.xs;
        line_ch.y_start  <= rq.ys;
        line_ch.x_end    <= rq.xe;
        line_ch.y_end    <= rq.ye;
        @(posedge i_clk);
        while (!line_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_plain(line_req_t rq);
        dir_row_t row;
        row.req = rq;
        row.typed = 0;
        row.has_pix = 0;
        row.pix = '{16'sd0, 16'sd0, 1'b0, 1'b0};
        send_req(rq, row);
    endtask

    task automatic send_tick();
        line_req_t rq;
        rq = '{REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom)};  // payload ignored
        send_plain(rq);
    endtask

    // let every result arrive, then cover line setups still queued or in flight
    task automatic drain();
        line_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_due.size() != 0 || typed_pend.size() != 0) @(posedge i_clk);
        repeat ((QUEUE_DEPTH + 1) * SETUP_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CLIP_LEFT:   win_l = val;
            CFG_CLIP_TOP:    win_t = val;
            CFG_CLIP_RIGHT:  win_r = val;
            CFG_CLIP_BOTTOM: win_b = val;
            CFG_OFFSET_X:    off_x = val;
            CFG_OFFSET_Y:    off_y = val;
            default:         brush_col = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_all(int l, int t, int r, int b, int ox, int oy, bit br);
        cfg_write(CFG_CLIP_LEFT,   16'(l));
        cfg_write(CFG_CLIP_TOP,    16'(t));
        cfg_write(CFG_CLIP_RIGHT,  16'(r));
        cfg_write(CFG_CLIP_BOTTOM, 16'(b));
        cfg_write(CFG_OFFSET_X,    16'(ox));
        cfg_write(CFG_OFFSET_Y,    16'(oy));
        cfg_write(CFG_BRUSH,       16'(br));
    endtask

    // a coordinate that lands near the window once the offset is added
    function automatic logic [15:0] near_coord(int lo, int hi, int off);
        int top;
        top = (hi > lo + 150) ? lo + 150 : hi;
        if (top < lo) top = lo;
        return 16'($urandom_range(top - lo + 40) + lo - 20 - off);
    endfunction

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    dir_row_t dir_rows[$];

    function automatic void add_row(logic rt, int xs, int ys, int xe, int ye,
                                    bit typed, bit has_pix, int px, int py,
                                    bit col, bit last);
        dir_row_t row;
        row.req     = '{rt, 16'(xs), 16'(ys), 16'(xe), 16'(ye)};
        row.typed   = typed;
        row.has_pix = has_pix;
        row.pix     = '{16'(px), 16'(py), col, last};
        dir_rows.push_back(row);
    endfunction

    initial begin
        line_req_t rq;
        int        n_lines_phase;
        int        sel, ticks;
        int        l, t, r, b, ox, oy;

        errors = 0; n_lines = 0; n_ticks = 0; n_pixels = 0; n_accepted_lines = 0;
        steady = 0;
        hold_cycles = 0;
        win_l = RST_CLIP_LEFT; win_t = RST_CLIP_TOP;
        win_r = RST_CLIP_RIGHT; win_b = RST_CLIP_BOTTOM;
        off_x = '0; off_y = '0; brush_col = RST_BRUSH;
        acc_x = 0; acc_y = 0; inc_x = 0; inc_y = 0; pix_remaining = 0;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        line_ch.valid = 1'b0; line_ch.req_type = REQ_LINE;
        line_ch.x_start = '0; line_ch.y_start = '0;
        line_ch.x_end = '0; line_ch.y_end = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window 0..127 x 0..63, brush 1
        add_row(REQ_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);          // idle tick
        add_row(REQ_LINE, 0, 0, 4, 0, 1, 0, 0, 0, 0, 0);          // short horizontal
        add_row(REQ_TICK, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 1, 1, 1, 0, 1, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 1, 1, 2, 0, 1, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 1, 1, 3, 0, 1, 1);          // far end not drawn
        add_row(REQ_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);          // line exhausted
        add_row(REQ_LINE, 200, 200, 300, 300, 1, 0, 0, 0, 0, 0);  // trivially rejected
        add_row(REQ_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(REQ_LINE, 5, 5, 5, 5, 1, 0, 0, 0, 0, 0);          // zero length
        add_row(REQ_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(REQ_LINE, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_LINE, 10, 60, 10, -50, 0, 0, 0, 0, 0, 0);     // up, clipped at top
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_LINE, -20, 70, 140, -10, 0, 0, 0, 0, 0, 0);   // clipped at both ends
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_LINE, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0);  // replaces
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i]);
        drain();

        // back-pressure: receiver holds off while ticks keep coming
        rq = '{REQ_LINE, 16'sd0, 16'sd2, 16'sd120, 16'sd40};
        send_plain(rq);
        hold_cycles = 400;
        repeat (60) send_tick();
        drain();

        // random phases over several window/offset/brush settings
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin l = 0; t = 0; r = 127; b = 63; ox = 0; oy = 0; end
                1: begin l = -32768; t = -32768; r = 32767; b = 32767; ox = 0; oy = 0; end
                2: begin l = 10; t = 10; r = 10; b = 10; ox = 32767; oy = -32768; end
                3: begin l = 50; t = 0; r = 40; b = 63; ox = 0; oy = 0; end  // empty
                4: begin l = 0; t = 30; r = 127; b = 20; ox = 5; oy = 5; end // empty
                5: begin l = 32700; t = 32700; r = 32767; b = 32767; ox = -32768; oy = 32767; end
                6: begin l = -32768; t = -32768; r = -32700; b = -32720; ox = 100; oy = -100; end
                default: begin
                    l = $urandom_range(400) - 200; t = $urandom_range(400) - 200;
                    r = l + $urandom_range(200); b = t + $urandom_range(200);
                    ox = $urandom_range(600) - 300; oy = $urandom_range(600) - 300;
                end
            endcase
            cfg_all(l, t, r, b, ox, oy, $urandom_range(1));
            steady = (ph == 2);
            n_lines_phase = 0;
            while (n_lines_phase < 14) begin
                sel = $urandom_range(99);
                if (sel < 80) begin
                    rq.req_type = REQ_LINE;
                    rq.xs = near_coord(l, r, ox); rq.ys = near_coord(t, b, oy);
                    rq.xe = near_coord(l, r, ox); rq.ye = near_coord(t, b, oy);
                end else if (sel < 92) begin
                    rq = '{REQ_LINE, 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom)};
                end else begin
                    rq.req_type = REQ_TICK;
                end
                if (rq.req_type == REQ_LINE) begin
                    send_plain(rq);
                    n_lines_phase++;
                end
                ticks = $urandom_range(20);
                repeat (ticks) send_tick();
                if ($urandom_range(9) == 0) drain();   // sender waits for all pixels
            end
            drain();
        end

        $display("covered %0d line commands (%0d drawable), %0d ticks, %0d pixels checked",
                 n_lines, n_accepted_lines, n_ticks, n_pixels);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
